// ===== rtl/dcmr_pkg.sv =====
`default_nettype none

package dcmr_pkg;

   // ramp duration width, fixed by the request format
   localparam int DURATION_BITS = 16;

   // floor(x / 100) == (x * PCT_RECIP) >> PCT_SHIFT for every x below 91180
   localparam int          PCT_SHIFT = 23;
   localparam int          RCP_BITS  = 33;
   localparam logic [16:0] PCT_RECIP = 17'd83887;

   localparam logic [7:0] PCT_LIMIT = 8'd100;
   localparam logic [7:0] RAW_LIMIT = 8'd255;

   // request kinds
   localparam logic [1:0] KIND_DIR  = 2'd0;
   localparam logic [1:0] KIND_PCT  = 2'd1;
   localparam logic [1:0] KIND_RAW  = 2'd2;
   localparam logic [1:0] KIND_TICK = 2'd3;

   // direction codes
   localparam logic [1:0] DIR_OFF = 2'd0;
   localparam logic [1:0] DIR_CW  = 2'd1;
   localparam logic [1:0] DIR_CCW = 2'd2;

   typedef struct packed {
      logic [1:0]               kind;
      logic                     motor_select;
      logic [7:0]               value;
      logic [DURATION_BITS-1:0] duration;
   } req_type;

   typedef struct packed {
      logic [7:0] pwm_a;
      logic       dir_a;
      logic [7:0] pwm_b;
      logic       dir_b;
      logic       ramping_a;
      logic       ramping_b;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture the accepted request
      logic div_start;  // launch the interval divide
      logic apply;      // commit the request to the motor state
      logic drv_sel;    // motor served by the duty pipeline
      logic drv_mul;    // duty stage 1: span * speed
      logic drv_rcp;    // duty stage 2: times reciprocal of 100
      logic drv_wr;     // duty stage 3: add floor, saturate, write pins
      logic out_load;   // load the response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_div;
      logic div_done;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/dcmr_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. Divisor is nonzero.
module dcmr_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [dcmr_pkg::DURATION_BITS-1:0] dividend,
   input  wire logic [7:0]                         divisor,
   output logic      [dcmr_pkg::DURATION_BITS-1:0] quotient,
   output logic                                    done
);

   localparam int DB = dcmr_pkg::DURATION_BITS;
   localparam int CW = $clog2(DB + 1);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [DB-1:0] quot_ff, quot_in;
   logic [7:0]    rem_ff, rem_in;
   logic [7:0]    dvs_ff, dvs_in;
   logic [8:0]    trial;
   logic          fits;

   assign trial = {rem_ff, quot_ff[DB-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         cnt_in  = CW'(DB);
         quot_in = dividend;
         rem_in  = 8'd0;
         dvs_in  = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
         quot_in = {quot_ff[DB-2:0], fits};
         rem_in  = fits ? 8'(trial - {1'b0, dvs_ff}) : trial[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ===== rtl/dcmr_datapath.sv =====
`default_nettype none

module dcmr_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [7:0]        csr_wdata,
   input  wire dcmr_pkg::req_type req_data,
   input  wire dcmr_pkg::cmd_type cmd,
   output dcmr_pkg::sts_type      sts,
   output dcmr_pkg::rsp_type      rsp_data
);

   localparam int DB    = dcmr_pkg::DURATION_BITS;
   localparam int RCP_W = dcmr_pkg::RCP_BITS;

   function automatic logic [7:0] step_toward(input logic [7:0] cur, input logic [7:0] tgt);
      logic [7:0] res;
      res = cur;
      if (cur < tgt)
         res = cur + 8'd1;
      else if (cur > tgt)
         res = cur - 8'd1;
      return res;
   endfunction

   dcmr_pkg::req_type req_ff, req_in;

   logic [7:0]    min_pwm_ff [2], min_pwm_in [2];
   logic [7:0]    cur_ff     [2], cur_in     [2];
   logic [7:0]    tgt_ff     [2], tgt_in     [2];
   logic [1:0]    dirs_ff    [2], dirs_in    [2];
   logic          raw_ff     [2], raw_in     [2];
   logic [DB-1:0] intv_ff    [2], intv_in    [2];
   logic [DB-1:0] tick_ff    [2], tick_in    [2];
   logic [7:0]    pwm_ff     [2], pwm_in     [2];
   logic          pin_ff     [2], pin_in     [2];
   logic [DB-1:0] tick_inc   [2];

   logic [15:0]          prod_ff, prod_in;
   logic [RCP_W-1:0]     rcp_ff,  rcp_in;

   dcmr_pkg::rsp_type rsp_ff, rsp_in;

   logic          m;
   logic [7:0]    tgt_req;
   logic [7:0]    distance;
   logic [DB-1:0] quot;
   logic          div_done;
   logic [9:0]    pct_q;
   logic [9:0]    duty_sum;
   logic [7:0]    duty_pct;

   assign m        = req_ff.motor_select;
   assign tgt_req  = (req_ff.kind == dcmr_pkg::KIND_RAW) ? req_ff.value :
                     ((req_ff.value > dcmr_pkg::PCT_LIMIT) ? dcmr_pkg::PCT_LIMIT : req_ff.value);
   assign distance = (tgt_req > cur_ff[m]) ? 8'(tgt_req - cur_ff[m]) :
                                             8'(cur_ff[m] - tgt_req);

   assign sts.need_div = ((req_ff.kind == dcmr_pkg::KIND_PCT) ||
                          (req_ff.kind == dcmr_pkg::KIND_RAW)) && (distance != 8'd0);
   assign sts.div_done = div_done;

   dcmr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (req_ff.duration),
      .divisor  (distance),
      .quotient (quot),
      .done     (div_done)
   );

   // duty stage 3 arithmetic
   assign pct_q    = rcp_ff[RCP_W-1:dcmr_pkg::PCT_SHIFT];
   assign duty_sum = {2'b00, min_pwm_ff[cmd.drv_sel]} + pct_q;
   assign duty_pct = (duty_sum > 10'd255) ? 8'hFF : duty_sum[7:0];

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         tick_inc[k] = tick_ff[k] + DB'(1);
      end
   end

   always_comb begin
      req_in     = cmd.load ? req_data : req_ff;
      min_pwm_in = min_pwm_ff;
      cur_in     = cur_ff;
      tgt_in     = tgt_ff;
      dirs_in    = dirs_ff;
      raw_in     = raw_ff;
      intv_in    = intv_ff;
      tick_in    = tick_ff;
      pwm_in     = pwm_ff;
      pin_in     = pin_ff;
      prod_in    = prod_ff;
      rcp_in     = rcp_ff;
      rsp_in     = rsp_ff;

      if (csr_we)
         min_pwm_in[csr_index] = csr_wdata;

      if (cmd.apply) begin
         case (req_ff.kind)
            dcmr_pkg::KIND_DIR: begin
               if (req_ff.value <= {6'd0, dcmr_pkg::DIR_CCW})
                  dirs_in[m] = req_ff.value[1:0];
            end
            dcmr_pkg::KIND_PCT, dcmr_pkg::KIND_RAW: begin
               raw_in[m]  = (req_ff.kind == dcmr_pkg::KIND_RAW);
               tgt_in[m]  = tgt_req;
               tick_in[m] = '0;
               if (distance == 8'd0) begin
                  intv_in[m] = '0;
               end else begin
                  intv_in[m] = quot;
                  cur_in[m]  = (quot == '0) ? tgt_req : step_toward(cur_ff[m], tgt_req);
               end
            end
            default: begin
               for (int k = 0; k < 2; k++) begin
                  if (cur_ff[k] != tgt_ff[k]) begin
                     if (tick_inc[k] >= intv_ff[k]) begin
                        cur_in[k]  = step_toward(cur_ff[k], tgt_ff[k]);
                        tick_in[k] = '0;
                     end else begin
                        tick_in[k] = tick_inc[k];
                     end
                  end
               end
            end
         endcase
      end

      if (cmd.drv_mul)
         prod_in = 16'(8'd255 - min_pwm_ff[cmd.drv_sel]) * 16'(cur_ff[cmd.drv_sel]);
      if (cmd.drv_rcp)
         rcp_in = RCP_W'(prod_ff) * RCP_W'(dcmr_pkg::PCT_RECIP);
      if (cmd.drv_wr) begin
         if ((cur_ff[cmd.drv_sel] == 8'd0) || (dirs_ff[cmd.drv_sel] == dcmr_pkg::DIR_OFF)) begin
            pwm_in[cmd.drv_sel] = 8'd0;
            pin_in[cmd.drv_sel] = 1'b0;
         end else begin
            pwm_in[cmd.drv_sel] = raw_ff[cmd.drv_sel] ? cur_ff[cmd.drv_sel] : duty_pct;
            pin_in[cmd.drv_sel] = (dirs_ff[cmd.drv_sel] == dcmr_pkg::DIR_CW);
         end
      end

      if (cmd.out_load) begin
         rsp_in.pwm_a     = pwm_ff[0];
         rsp_in.dir_a     = pin_ff[0];
         rsp_in.pwm_b     = pwm_ff[1];
         rsp_in.dir_b     = pin_ff[1];
         rsp_in.ramping_a = (cur_ff[0] != tgt_ff[0]);
         rsp_in.ramping_b = (cur_ff[1] != tgt_ff[1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 2; k++) begin
            min_pwm_ff[k] <= 8'd0;
            cur_ff[k]     <= 8'd0;
            tgt_ff[k]     <= 8'd0;
            dirs_ff[k]    <= dcmr_pkg::DIR_OFF;
            raw_ff[k]     <= 1'b0;
            intv_ff[k]    <= '0;
            tick_ff[k]    <= '0;
            pwm_ff[k]     <= 8'd0;
            pin_ff[k]     <= 1'b0;
         end
      end else begin
         min_pwm_ff <= min_pwm_in;
         cur_ff     <= cur_in;
         tgt_ff     <= tgt_in;
         dirs_ff    <= dirs_in;
         raw_ff     <= raw_in;
         intv_ff    <= intv_in;
         tick_ff    <= tick_in;
         pwm_ff     <= pwm_in;
         pin_ff     <= pin_in;
      end
      req_ff  <= req_in;
      prod_ff <= prod_in;
      rcp_ff  <= rcp_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/dcmr_ctrl.sv =====
`default_nettype none

module dcmr_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire dcmr_pkg::sts_type sts,
   output dcmr_pkg::cmd_type      cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LATCH,
      ST_DIV,
      ST_APPLY,
      ST_MUL,
      ST_RCP,
      ST_WR,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      motor_ff, motor_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      motor_in     = motor_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.drv_sel  = motor_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LATCH;
            end
         end
         ST_LATCH: begin
            cmd.div_start = sts.need_div;
            state_in      = sts.need_div ? ST_DIV : ST_APPLY;
         end
         ST_DIV: begin
            if (sts.div_done)
               state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            motor_in  = 1'b0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.drv_mul = 1'b1;
            state_in    = ST_RCP;
         end
         ST_RCP: begin
            cmd.drv_rcp = 1'b1;
            state_in    = ST_WR;
         end
         ST_WR: begin
            cmd.drv_wr = 1'b1;
            motor_in   = 1'b1;
            state_in   = motor_ff ? ST_RESP : ST_MUL;
         end
         ST_RESP: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         motor_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         motor_ff     <= motor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/dual_dc_motor_ramp_driver.sv =====
`default_nettype none

// Two-channel DC motor driver with independent speed ramps. Each request is
// a direction, percent-speed, raw-speed or tick command and returns one
// response holding both motors' PWM duty, direction pins and ramping flags.
// Percent duty is min_pwm + (255 - min_pwm) * speed / 100, saturating at 255;
// raw duty is the speed itself; zero speed or direction off gives duty 0 and
// a low pin. A speed command sets the ramp interval to duration / distance and
// steps once at once, or jumps to the target if that interval is zero; ticks
// then step each ramping motor one unit per interval. A request runs the update
// state and then a 3-stage duty pipeline once per motor before its response is
// loaded; speed commands that change the speed first run the serial interval
// divider. One request is in work at a time; the next is accepted while the
// previous response still waits in the output register. min_pwm writes (csr
// index 0 motor A, 1 motor B) take effect when the duty pipeline next runs for
// that motor.
module dual_dc_motor_ramp_driver (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire dcmr_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output dcmr_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [7:0]        csr_wdata
);

   dcmr_pkg::cmd_type cmd;
   dcmr_pkg::sts_type sts;

   // sequencer: accept, divide, update, duty pipeline per motor, respond
   dcmr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // motor state, serial divider, duty arithmetic and response register
   dcmr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
